/* rtl/core/echo_distance_moving_average_defines.svh */
// ---------------------------------------------------------------------------
// assertion macros for the echo distance moving average block
// ---------------------------------------------------------------------------
`ifndef ECHO_DISTANCE_MOVING_AVERAGE_DEFINES_SVH
`define ECHO_DISTANCE_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EDMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define EDMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/edma_pkg.sv */
// ---------------------------------------------------------------------------
// edma_pkg
// shared constants and types of the echo distance moving average block
// ---------------------------------------------------------------------------
`default_nettype none

package edma_pkg;

  localparam int unsigned EchoW   = 20;
  localparam int unsigned DistW   = 15;
  localparam int unsigned DistMax = 17983;

  // cm = floor(us * 343 / 20000), done as us * CmMul >> CmShift
  localparam int unsigned CmNum   = 343;
  localparam int unsigned CmDen   = 20000;
  localparam int unsigned CmShift = 35;
  localparam int unsigned CmMulW  = 30;
  localparam longint unsigned CmMulFull =
    ((64'(CmNum) << CmShift) + 64'(CmDen) - 64'd1) / 64'(CmDen);
  localparam logic [CmMulW-1:0] CmMul = CmMulW'(CmMulFull);
  localparam int unsigned ProdW   = EchoW + CmMulW;

  localparam int unsigned WindowDef = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DIV
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/edma_ram.sv */
// ---------------------------------------------------------------------------
// edma_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module edma_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/edma_conv.sv */
// ---------------------------------------------------------------------------
// edma_conv
// echo time to centimetres by a registered reciprocal multiply
// ---------------------------------------------------------------------------
`default_nettype none

module edma_conv (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [edma_pkg::EchoW-1:0]    echo_us_i,
  output logic      [edma_pkg::DistW-1:0]    distance_o
);

  import edma_pkg::*;

  logic [ProdW-1:0] prod;
  logic [DistW-1:0] dist_q;

  // reciprocal is rounded up; its error stays below one step of the quotient
  assign prod = {{CmMulW{1'b0}}, echo_us_i} * {{EchoW{1'b0}}, CmMul};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= prod[CmShift +: DistW];
    end
  end

  assign distance_o = dist_q;

endmodule

`default_nettype wire

/* rtl/core/edma_div.sv */
// ---------------------------------------------------------------------------
// edma_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module edma_div #(
  parameter int unsigned NumW = 18,
  parameter int unsigned DenW = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic      [NumW-1:0] quot_o
);

  import edma_pkg::*;

  localparam int unsigned CntW = ($clog2(NumW) > 0) ? $clog2(NumW) : 1;

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   shifted;
  logic [DenW:0]   trial;
  logic            fits;

  assign shifted = {rem_q, quo_q[NumW-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW - 1);
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_d = fits ? trial[DenW-1:0] : shifted[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* rtl/core/echo_distance_moving_average.sv */
// ---------------------------------------------------------------------------
// echo_distance_moving_average
// echo time to distance with a boxcar moving average and warm-up
// ---------------------------------------------------------------------------
// usage:
//   input channel in_valid_i / in_ready_o carries one echo time in us per beat
//   output channel out_valid_o / out_ready_i carries the instant distance and
//   the truncated average of the stored distances, this one included
//   one result beat per input beat, in order
//   a beat passes the echo register, the conversion register, the sum update
//   and the bit-serial divider that forms the average, one quotient bit a
//   cycle, to the result register; only then is the next input beat taken
//   samples live in a WINDOW-entry ram, read then written back once per beat
//   reset clears the running sum, write position and filled flag; the ram is
//   not cleared, its read data is only used once every entry has been written
//   a stalled receiver holds the result register; the next input beat is
//   still taken, and its result waits until the output register is free
// ---------------------------------------------------------------------------
`default_nettype none
`include "echo_distance_moving_average_defines.svh"

module echo_distance_moving_average #(
  parameter int unsigned WINDOW = edma_pkg::WindowDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [edma_pkg::EchoW-1:0]   echo_us_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [edma_pkg::DistW-1:0]   distance_cm_o,
  output logic      [edma_pkg::DistW-1:0]   average_cm_o
);

  import edma_pkg::*;

  localparam int unsigned PosW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW   = $clog2(WINDOW + 1);
  localparam int unsigned SumMax = WINDOW * DistMax;
  localparam int unsigned SumW   = $clog2(SumMax + 1);

  state_e state_q, state_d;

  logic [EchoW-1:0] echo_q;
  logic [SumW-1:0]  running_sum_q, running_sum_d;
  logic [PosW-1:0]  write_pos_q, write_pos_d;
  logic             ring_filled_q, ring_filled_d;
  logic             out_valid_q, out_valid_d;
  logic [DistW-1:0] distance_q;
  logic [DistW-1:0] average_q;

  logic             in_accept;
  logic             conv_en;
  logic [DistW-1:0] dist_cm;
  logic             ram_we;
  logic [DistW-1:0] old_sample;
  logic             div_start;
  logic             div_busy;
  logic [CntW-1:0]  div_den;
  logic [SumW-1:0]  div_quot;
  logic             out_load;

  assign in_accept = in_valid_i && in_ready_o;

  edma_conv u_conv (
    .clk_i      (clk_i),
    .en_i       (conv_en),
    .echo_us_i  (echo_q),
    .distance_o (dist_cm)
  );

  edma_ram #(
    .Width (DistW),
    .Depth (WINDOW),
    .AddrW (PosW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (write_pos_q),
    .wdata_i (dist_cm),
    .re_i    (in_accept),
    .raddr_i (write_pos_q),
    .rdata_o (old_sample)
  );

  edma_div #(
    .NumW (SumW),
    .DenW (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (running_sum_d),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    conv_en       = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    running_sum_d = running_sum_q;
    write_pos_d   = write_pos_q;
    ring_filled_d = ring_filled_q;
    div_den       = ring_filled_q ? CntW'(WINDOW) : (CntW'(write_pos_q) + CntW'(1));
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        conv_en = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // oldest sample leaves the sum once the ring has wrapped
        running_sum_d = running_sum_q + SumW'(dist_cm)
                        - (ring_filled_q ? SumW'(old_sample) : SumW'(0));
        ram_we    = 1'b1;
        div_start = 1'b1;
        if (write_pos_q == PosW'(WINDOW - 1)) begin
          write_pos_d   = '0;
          ring_filled_d = 1'b1;
        end else begin
          write_pos_d = write_pos_q + PosW'(1);
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      running_sum_q <= '0;
      write_pos_q   <= '0;
      ring_filled_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      running_sum_q <= running_sum_d;
      write_pos_q   <= write_pos_d;
      ring_filled_q <= ring_filled_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      echo_q <= echo_us_i;
    end
    if (out_load) begin
      distance_q <= dist_cm;
      average_q  <= div_quot[DistW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_cm_o = distance_q;
  assign average_cm_o  = average_q;

  `EDMA_ASSERT_NOW(a_sum_bound, 1'b1, running_sum_q <= SumW'(SumMax), "running sum out of range")
  `EDMA_ASSERT_NOW(a_pos_bound, 1'b1, write_pos_q <= PosW'(WINDOW - 1), "write position out of range")
  `EDMA_ASSERT_NEXT(a_filled_stays, ring_filled_q, ring_filled_q, "ring filled flag dropped")
  `EDMA_ASSERT_NOW(a_div_idle, state_q == ST_IDLE || state_q == ST_MUL, !div_busy, "divider busy outside average phase")
  `EDMA_ASSERT_NEXT(a_out_load, out_load, out_valid_q, "result beat not presented after load")

endmodule

`default_nettype wire

/* sim/echo_distance_moving_average_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// echo_distance_moving_average_tb
// checks the echo to distance conversion and the warm-up boxcar average
// against a cycle-free predictor, beat by beat, under random idling on both
// channels, a long output stall and a full drain halfway through
// ---------------------------------------------------------------------------

typedef struct packed {
  logic [edma_pkg::DistW-1:0] distance;
  logic [edma_pkg::DistW-1:0] average;
} reading_t;

class sonar_average_scoreboard;
  localparam int unsigned Depth = edma_pkg::WindowDef;

  logic [edma_pkg::DistW-1:0] history[Depth];
  logic [17:0]                sum;
  int unsigned                slot;
  bit                         full;
  reading_t                   pending[$];
  int unsigned                errors;

  function void clear();
    sum    = '0;
    slot   = 0;
    full   = 1'b0;
    errors = 0;
    pending.delete();
  endfunction

  // predict the reading that one accepted echo beat produces
  function void note_echo(logic [edma_pkg::EchoW-1:0] echo_us);
    reading_t                   r;
    logic [edma_pkg::DistW-1:0] cm;
    cm = edma_pkg::DistW'((64'(echo_us) * edma_pkg::CmNum) / edma_pkg::CmDen);
    if (full) begin
      sum = sum - history[slot] + cm;
    end else begin
      sum = sum + cm;
    end
    history[slot] = cm;
    r.distance = cm;
    // warm-up divides by the samples seen so far
    r.average  = full ? edma_pkg::DistW'(sum / Depth)
                      : edma_pkg::DistW'(sum / (slot + 1));
    pending.push_back(r);
    slot = slot + 1;
    if (slot == Depth) begin
      slot = 0;
      full = 1'b1;
    end
  endfunction

  function void check_reading(logic [edma_pkg::DistW-1:0] distance,
                              logic [edma_pkg::DistW-1:0] average);
    reading_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat distance=%0d average=%0d",
               $time, distance, average);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (distance !== exp_r.distance) begin
      $display("%0t: distance_cm expected %0d got %0d", $time, exp_r.distance, distance);
      errors++;
    end
    if (average !== exp_r.average) begin
      $display("%0t: average_cm expected %0d got %0d", $time, exp_r.average, average);
      errors++;
    end
  endfunction
endclass

module echo_distance_moving_average_tb;
  import edma_pkg::*;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned SettleTicks = 40;
  localparam int unsigned RandItems   = 1100;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [EchoW-1:0] echo_us_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DistW-1:0] distance_cm_o;
  logic [DistW-1:0] average_cm_o;

  sonar_average_scoreboard sb = new;

  bit          no_gaps;
  bit          hold_request;
  bit          hold_taken = 1'b0;
  int unsigned idle_cycles = 0;

  echo_distance_moving_average DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .echo_us_i     (echo_us_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .distance_cm_o (distance_cm_o),
    .average_cm_o  (average_cm_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // offer one echo beat after a random gap, return at the accepting edge
  task automatic send_echo(input logic [EchoW-1:0] echo_us);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    echo_us_i  <= echo_us;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_echo(echo_us);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [EchoW-1:0] random_echo();
    int unsigned pick;
    int unsigned cm;
    longint unsigned us;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return EchoW'($urandom);
    end else if (pick < 70) begin
      return EchoW'($urandom_range(0, 2000));
    end else if (pick < 85) begin
      return EchoW'($urandom_range(1040000, 2**EchoW - 1));
    end else if (pick < 95) begin
      // land on or just below a whole-centimetre step
      cm = $urandom_range(1, DistMax);
      us = (longint'(cm) * CmDen + CmNum - 1) / CmNum - $urandom_range(0, 1);
      if (us > 2**EchoW - 1) us = 2**EchoW - 1;
      return EchoW'(us);
    end
    return '0;
  endfunction

  // output side: random stalls, one long hold on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        gap = LongHold;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_reading(distance_cm_o, average_cm_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [EchoW-1:0] directed[$];
    sb.clear();
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // warm-up over timeout, step edges and extremes, then wrap into
    // a full window of maximum and a full window of timeouts
    directed = '{0, 1, 58, 59, EchoW'(2**EchoW - 1), EchoW'(2**EchoW - 2), 20000, 19999};
    repeat (8) directed.push_back(EchoW'(2**EchoW - 1));
    repeat (8) directed.push_back('0);
    directed.push_back(EchoW'(524288));
    foreach (directed[i]) send_echo(directed[i]);

    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n % 100 == 0) no_gaps = ((n / 100) % 4 == 1);
      if (n == 300) hold_request = 1'b1;
      if (n == 600) begin
        // stop offering until the pipeline has fully emptied
        in_valid_i <= 1'b0;
        wait_drained();
        repeat (SettleTicks) @(posedge clk_i);
      end
      send_echo(random_echo());
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (SettleTicks) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/edma_pkg.sv
rtl/core/edma_ram.sv
rtl/core/edma_conv.sv
rtl/core/edma_div.sv
rtl/core/echo_distance_moving_average.sv
sim/echo_distance_moving_average_tb.sv
